### rtl/mfsw_pkg.sv
package mfsw_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_KERNEL = 7;

   localparam int PIX_W  = 8;
   localparam int KSZ_W  = 3;
   localparam int DIM_W  = 11;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int BANK_W = $clog2(MAX_KERNEL);
   localparam int WIN_N  = MAX_KERNEL * MAX_KERNEL;
   localparam int CNT_W  = $clog2(WIN_N + 1);
   localparam int LAG_W  = $clog2((MAX_KERNEL / 2) * MAX_WIDTH + MAX_KERNEL / 2 + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic [KSZ_W-1:0] KERNEL_RESET = KSZ_W'(3);
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1024);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1024);

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_idx_type;

   // RAM side of one accepted word
   typedef struct packed {
      logic             wr;
      logic [BANK_W-1:0] wbank;
      logic [COL_W-1:0] waddr;
      logic [PIX_W-1:0] pix;
      logic [COL_W-1:0] laddr;
      logic [COL_W-1:0] caddr;
   } mem_ctl_type;

   // output step handed to the window stage
   typedef struct packed {
      logic             valid;
      logic             eof;
      logic             pass;
      logic             lag0;
      logic             fwd;
      logic [BANK_W-1:0] lbank;
      logic [BANK_W-1:0] cbank;
      logic [KSZ_W-1:0] k;
      logic [PIX_W-1:0] pix;
   } step_type;

   // tag travelling along the median pipeline
   typedef struct packed {
      logic             valid;
      logic             eof;
      logic             pass;
      logic [KSZ_W-1:0] k;
      logic [PIX_W-1:0] center;
   } med_tag_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int hi);
      if (v == '0) return DIM_W'(1);
      if (int'(v) > hi) return DIM_W'(hi);
      return v;
   endfunction

   // x < 3*MAX_KERNEL
   function automatic logic [BANK_W-1:0] bank_mod(input logic [BANK_W+1:0] x);
      logic [BANK_W+1:0] v;
      v = x;
      for (int s = 0; s < 3; s++) begin
         if (v >= (BANK_W+2)'(MAX_KERNEL)) v = v - (BANK_W+2)'(MAX_KERNEL);
      end
      return v[BANK_W-1:0];
   endfunction

   function automatic logic [BANK_W-1:0] bank_next(input logic [BANK_W-1:0] b);
      if (b == BANK_W'(MAX_KERNEL - 1)) return '0;
      return b + BANK_W'(1);
   endfunction

   function automatic logic [CNT_W-1:0] half_idx(input logic [KSZ_W-1:0] k);
      return CNT_W'((int'(k) * int'(k)) / 2);
   endfunction

endpackage

### rtl/mfsw_ram.sv
module mfsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // read returns old data on a same-address write
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

### rtl/mfsw_ctrl.sv
module mfsw_ctrl import mfsw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  logic                 fire,
   input  logic                 mode,
   input  logic [PIX_W-1:0]     pixel,
   output step_type             step,
   output mem_ctl_type          mem
);

   logic [KSZ_W-1:0]  k_cfg_ff, cur_k_ff;
   logic [DIM_W-1:0]  w_cfg_ff, h_cfg_ff, cur_w_ff, cur_h_ff;
   logic              open_ff, done_ff;
   logic [ROW_W-1:0]  ii_ff, oi_ff;
   logic [COL_W-1:0]  ij_ff, oj_ff, lj_ff;
   logic [BANK_W-1:0] ib_ff, ob_ff, lb_ff;
   logic [LAG_W-1:0]  diff_ff;

   logic              pix_in, start, filt, wr, emit, in_last, out_last, pass;
   logic [KSZ_W-1:0]  k_e, o_e;
   logic [DIM_W-1:0]  w_e, h_e;
   logic [LAG_W-1:0]  lag;
   logic [COL_W-1:0]  lj_e;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_cfg_ff <= KERNEL_RESET;
         w_cfg_ff <= WIDTH_RESET;
         h_cfg_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_KERNEL: k_cfg_ff <= csr_wdata[KSZ_W-1:0];
            CSR_WIDTH:  w_cfg_ff <= csr_wdata;
            CSR_HEIGHT: h_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      pix_in = fire && (mode == MODE_PIXEL);
      start  = pix_in && !open_ff;
      k_e    = start ? k_cfg_ff : cur_k_ff;
      w_e    = start ? clamp_dim(w_cfg_ff, MAX_WIDTH) : cur_w_ff;
      h_e    = start ? clamp_dim(h_cfg_ff, MAX_HEIGHT) : cur_h_ff;
      filt   = k_e[0] && ({1'b0, k_e} <= (KSZ_W+1)'(MAX_KERNEL));
      o_e    = filt ? (k_e >> 1) : '0;
      lag    = LAG_W'(o_e) * LAG_W'(w_e) + LAG_W'(o_e);
      lj_e   = start ? COL_W'(o_e) : lj_ff;
      wr     = pix_in && !done_ff;
      emit   = (wr && (diff_ff >= lag)) || (fire && done_ff);
      in_last  = ({1'b0, ii_ff} == h_e - DIM_W'(1)) && ({1'b0, ij_ff} == w_e - DIM_W'(1));
      out_last = ({1'b0, oi_ff} == h_e - DIM_W'(1)) && ({1'b0, oj_ff} == w_e - DIM_W'(1));
      pass   = !filt
            || (DIM_W'(oi_ff) < DIM_W'(o_e)) || (DIM_W'(oj_ff) < DIM_W'(o_e))
            || (DIM_W'(oi_ff) + DIM_W'(o_e) >= h_e)
            || (DIM_W'(oj_ff) + DIM_W'(o_e) >= w_e);

      step.valid = emit;
      step.eof   = emit && out_last;
      step.pass  = pass;
      step.lag0  = (lag == '0);
      step.fwd   = wr;
      step.lbank = lb_ff;
      step.cbank = ob_ff;
      step.k     = k_e;
      step.pix   = pixel;

      mem.wr    = wr;
      mem.wbank = ib_ff;
      mem.waddr = ij_ff;
      mem.pix   = pixel;
      mem.laddr = lj_e;
      mem.caddr = oj_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_k_ff <= KERNEL_RESET;
         cur_w_ff <= WIDTH_RESET;
         cur_h_ff <= HEIGHT_RESET;
         open_ff  <= 1'b0;
         done_ff  <= 1'b0;
         ii_ff <= '0; ij_ff <= '0; ib_ff <= '0;
         oi_ff <= '0; oj_ff <= '0; ob_ff <= '0;
         lj_ff <= '0; lb_ff <= '0;
         diff_ff <= '0;
      end else begin
         if (start) begin
            cur_k_ff <= k_e;
            cur_w_ff <= w_e;
            cur_h_ff <= h_e;
            open_ff  <= 1'b1;
         end
         if (wr) begin
            if ({1'b0, ij_ff} == w_e - DIM_W'(1)) begin
               ij_ff <= '0;
               ii_ff <= ii_ff + ROW_W'(1);
               ib_ff <= bank_next(ib_ff);
            end else begin
               ij_ff <= ij_ff + COL_W'(1);
            end
            if (in_last) done_ff <= 1'b1;
         end
         if (emit) begin
            if ({1'b0, oj_ff} == w_e - DIM_W'(1)) begin
               oj_ff <= '0;
               oi_ff <= oi_ff + ROW_W'(1);
               ob_ff <= bank_next(ob_ff);
            end else begin
               oj_ff <= oj_ff + COL_W'(1);
            end
            if (DIM_W'(lj_e) >= w_e - DIM_W'(1)) begin
               lj_ff <= '0;
               lb_ff <= bank_next(lb_ff);
            end else begin
               lj_ff <= lj_e + COL_W'(1);
            end
         end else begin
            lj_ff <= lj_e;
         end
         if (wr && !emit) diff_ff <= diff_ff + LAG_W'(1);
         else if (!wr && emit) diff_ff <= diff_ff - LAG_W'(1);
         if (emit && out_last) begin
            open_ff <= 1'b0;
            done_ff <= 1'b0;
            ii_ff <= '0; ij_ff <= '0; ib_ff <= '0;
            oi_ff <= '0; oj_ff <= '0; ob_ff <= '0;
            lj_ff <= '0; lb_ff <= '0;
            diff_ff <= '0;
         end
      end
   end

`ifndef SYNTHESIS
   a_bank_range: assert property (@(posedge clock) disable iff (reset)
      (ib_ff < BANK_W'(MAX_KERNEL)) && (ob_ff < BANK_W'(MAX_KERNEL))
      && (lb_ff < BANK_W'(MAX_KERNEL)))
      else $error("row bank counter out of range");
   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      step.eof |=> !open_ff && !done_ff)
      else $error("frame not closed after last word");
   a_no_write_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !mem.wr)
      else $error("row store written after frame complete");
`endif

endmodule

### rtl/mfsw_median.sv
module mfsw_median import mfsw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  med_tag_type      tag_in,
   input  logic [PIX_W-1:0] elem [WIN_N],
   output med_tag_type      tag_out,
   output logic [PIX_W-1:0] value
);

   // rank stage: lt[m][n] = element n counts below element m
   logic [WIN_N-1:0] lt_ff [WIN_N];
   logic [WIN_N-1:0] mask_ff, mask4_ff, mask;
   logic [PIX_W-1:0] elem_ff [WIN_N];
   logic [PIX_W-1:0] elem4_ff [WIN_N];
   med_tag_type      tag3_ff, tag4_ff;
   logic [CNT_W-1:0] cnt_lt_ff [WIN_N];
   logic [CNT_W-1:0] cnt_le_ff [WIN_N];
   logic [CNT_W-1:0] cnt_lt [WIN_N];
   logic [CNT_W-1:0] cnt_le [WIN_N];
   logic [WIN_N-1:0] lt [WIN_N];
   logic [PIX_W-1:0] med;
   logic [CNT_W-1:0] half;

   // active window: columns MAX_KERNEL-k up, rows below k
   always_comb begin
      for (int m = 0; m < WIN_N; m++) begin
         mask[m] = ((m / MAX_KERNEL) >= (MAX_KERNEL - int'(tag_in.k)))
                && ((m % MAX_KERNEL) < int'(tag_in.k));
      end
      for (int m = 0; m < WIN_N; m++) begin
         for (int n = 0; n < WIN_N; n++) begin
            lt[m][n] = mask[n] && (elem[n] < elem[m]);
         end
      end
   end

   always_comb begin
      for (int m = 0; m < WIN_N; m++) begin
         cnt_lt[m] = '0;
         cnt_le[m] = '0;
         for (int n = 0; n < WIN_N; n++) begin
            cnt_lt[m] = cnt_lt[m] + CNT_W'(lt_ff[m][n]);
            cnt_le[m] = cnt_le[m] + CNT_W'(mask_ff[n] && !lt_ff[n][m]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else if (en) begin
         tag3_ff <= tag_in;
         tag4_ff <= tag3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lt_ff    <= lt;
         mask_ff  <= mask;
         elem_ff  <= elem;
         mask4_ff <= mask_ff;
         elem4_ff <= elem_ff;
         cnt_lt_ff <= cnt_lt;
         cnt_le_ff <= cnt_le;
      end
   end

   // equal candidates hold equal values, so an OR picks any of them
   always_comb begin
      half = half_idx(tag4_ff.k);
      med  = '0;
      for (int m = 0; m < WIN_N; m++) begin
         if (mask4_ff[m] && (cnt_lt_ff[m] <= half) && (cnt_le_ff[m] > half))
            med = med | elem4_ff[m];
      end
      value   = tag4_ff.pass ? tag4_ff.center : med;
      tag_out = tag4_ff;
   end

endmodule

### rtl/median_filter_square_window_core.sv
// K x K square-window median filter for 8-bit grayscale frames.
// req_ carries one word per pixel in raster order (tuser = 0) or a flush
// word (tuser = 1); rsp_ gives each pixel replaced by the median of its
// window, border pixels unchanged, tlast on the last pixel of the frame.
// kernel_size, frame_width and frame_height are written on csr_ and are
// taken up when the first pixel of a frame is accepted.
// With an odd kernel a result is caused by the word that brings pixel
// p + O*width + O; once the frame is in, each flush word drains one result.
// Throughput is one word per clock unless rsp_ stalls. A result reaches rsp_
// through the row store read, window shift, compare matrix, rank count and
// output register, in that order, after the word that causes it.
// Row store: one two-read-port RAM per window row (7 x 1024 bytes); port A
// fetches the next window column, port B the centre pixel for the border.
// Reset clears the frame counters and pipeline valids; the row store is not
// cleared. When rsp_tready is low with a word held, the whole pipeline and
// req_tready stall together; nothing is lost.
module median_filter_square_window_core import mfsw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] pixel_value
   input  logic [0:0]           req_tuser,   // [0] mode
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] filtered_value
   output logic                 rsp_tlast,   // end_of_frame
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   logic        adv, fire;
   step_type    step, s1_ff;
   mem_ctl_type mem;

   logic [PIX_W-1:0] rd_a [MAX_KERNEL];
   logic [PIX_W-1:0] rd_b [MAX_KERNEL];
   logic [PIX_W-1:0] col [MAX_KERNEL];
   logic [PIX_W-1:0] win_ff [MAX_KERNEL][MAX_KERNEL];   // [column][row]
   logic [PIX_W-1:0] elem [WIN_N];
   logic [PIX_W-1:0] center;
   logic [KSZ_W-1:0] o1;
   med_tag_type      tag2_ff, med_tag;
   logic [PIX_W-1:0] med_value;

   logic             rsp_valid_ff, rsp_last_ff;
   logic [PIX_W-1:0] rsp_data_ff;

   // output register frees the pipeline as soon as it is taken
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign fire       = req_tvalid && adv;

   mfsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .mode      (req_tuser[0]),
      .pixel     (req_tdata),
      .step      (step),
      .mem       (mem)
   );

   for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
      mfsw_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row (
         .clock   (clock),
         .we      (mem.wr && (mem.wbank == BANK_W'(b))),
         .waddr   (mem.waddr),
         .wdata   (mem.pix),
         .re      (adv),
         .raddr_a (mem.laddr),
         .raddr_b (mem.caddr),
         .rdata_a (rd_a[b]),
         .rdata_b (rd_b[b])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) s1_ff <= '0;
      else if (adv) s1_ff <= step;
   end

   // assemble the incoming column; bottom row is the pixel written
   // in the same cycle, so it comes from the word itself
   always_comb begin
      o1 = s1_ff.k >> 1;
      for (int t = 0; t < MAX_KERNEL; t++) begin
         col[t] = rd_a[bank_mod((BANK_W+2)'(s1_ff.lbank) + (BANK_W+2)'(MAX_KERNEL)
                                - (BANK_W+2)'(o1) + (BANK_W+2)'(t))];
         if (s1_ff.fwd && (t == int'(s1_ff.k) - 1)) col[t] = s1_ff.pix;
      end
      center = s1_ff.lag0 ? s1_ff.pix : rd_b[s1_ff.cbank];
   end

   always_ff @(posedge clock) begin
      if (adv && s1_ff.valid) begin
         for (int c = 0; c < MAX_KERNEL - 1; c++) win_ff[c] <= win_ff[c+1];
         win_ff[MAX_KERNEL-1] <= col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
      end else if (adv) begin
         tag2_ff.valid  <= s1_ff.valid;
         tag2_ff.eof    <= s1_ff.eof;
         tag2_ff.pass   <= s1_ff.pass;
         tag2_ff.k      <= s1_ff.k;
         tag2_ff.center <= center;
      end
   end

   always_comb begin
      for (int m = 0; m < WIN_N; m++) begin
         elem[m] = win_ff[m / MAX_KERNEL][m % MAX_KERNEL];
      end
   end

   mfsw_median u_median (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .tag_in  (tag2_ff),
      .elem    (elem),
      .tag_out (med_tag),
      .value   (med_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= med_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= med_value;
         rsp_last_ff <= med_tag.eof;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
